// ----- src/tsd_pkg.sv -----
// ---------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants for the two-stack deque.
// ---------------------------------------------------------------------------
package tsd_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int STACK_DEPTH_DEF = 128;

    localparam logic [OP_W-1:0] OP_INS_FRONT  = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_REAR   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic        [OP_W-1:0]   opcode;
        logic signed [DATA_W-1:0] value;
    } req_word_t;

    typedef struct packed {
        logic        [STATUS_W-1:0] status;
        logic signed [DATA_W-1:0]   data;
    } rsp_word_t;

endpackage

// ----- src/tsd_stack_mem.sv -----
// ---------------------------------------------------------------------------
// tsd_stack_mem
// Stack storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tsd_stack_mem #(
    parameter int DEPTH = tsd_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [tsd_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [tsd_pkg::DATA_W-1:0] rd_data
);

    logic [tsd_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/two_stack_deque_unit.sv -----
// ---------------------------------------------------------------------------
// two_stack_deque_unit
// Double-ended queue held in two bounded stacks, each in its own memory.
//
//   channel | handshake           | word
//   --------+---------------------+-------------------------------
//   req     | req_valid/req_stall | tsd_pkg::req_word_t (opcode, value)
//   rsp     | rsp_valid/rsp_stall | tsd_pkg::rsp_word_t (status, data)
//
// Insert completes in EXEC. Delete/peek reads the stack in EXEC and returns the
// registered read data from READ. Delete/peek on an empty side first moves the
// other stack across, one entry a cycle, through XFER before returning to EXEC.
// One word in flight; req_stall is high until its result sits in the output
// register, so a new word is taken while an old result waits on rsp_stall.
// Reset clears both counts; memory contents need no clearing.
// ---------------------------------------------------------------------------
module two_stack_deque_unit #(
    parameter int STACK_DEPTH = tsd_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  tsd_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tsd_pkg::rsp_word_t rsp
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    typedef enum logic [1:0] {IDLE, EXEC, READ, XFER} state_t;

    state_t                      state_reg, state_next;
    logic [tsd_pkg::OP_W-1:0]    op_reg, op_next;
    logic [tsd_pkg::DATA_W-1:0]  val_reg, val_next;
    logic [CW-1:0]               fcnt_reg, fcnt_next;
    logic [CW-1:0]               rcnt_reg, rcnt_next;
    logic                        pend_reg, pend_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    tsd_pkg::rsp_word_t          rsp_reg, rsp_next;

    logic                        side;
    logic                        out_free;
    logic                        remove;
    logic [CW-1:0]               own_cnt, oth_cnt, own_cnt_n, oth_cnt_n;
    logic                        own_rd, own_wr, oth_rd;
    logic [AW-1:0]               own_rd_addr, own_wr_addr, oth_rd_addr;
    logic [tsd_pkg::DATA_W-1:0]  own_wr_data;
    logic [CW-1:0]               own_dec, oth_dec;

    logic                        f_wr_en, r_wr_en, f_rd_en, r_rd_en;
    logic [AW-1:0]               f_rd_addr, r_rd_addr;
    logic [tsd_pkg::DATA_W-1:0]  f_rd_data, r_rd_data, own_rd_data, oth_rd_data;

    tsd_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_front (
        .clk     (clk),
        .wr_en   (f_wr_en),
        .wr_addr (own_wr_addr),
        .wr_data (own_wr_data),
        .rd_en   (f_rd_en),
        .rd_addr (f_rd_addr),
        .rd_data (f_rd_data)
    );

    tsd_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_rear (
        .clk     (clk),
        .wr_en   (r_wr_en),
        .wr_addr (own_wr_addr),
        .wr_data (own_wr_data),
        .rd_en   (r_rd_en),
        .rd_addr (r_rd_addr),
        .rd_data (r_rd_data)
    );

    // odd opcodes act on the rear side
    assign side        = op_reg[0];
    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign remove      = (op_reg == tsd_pkg::OP_DEL_FRONT) || (op_reg == tsd_pkg::OP_DEL_REAR);
    assign own_cnt     = side ? rcnt_reg : fcnt_reg;
    assign oth_cnt     = side ? fcnt_reg : rcnt_reg;
    assign own_dec     = own_cnt - CW'(1);
    assign oth_dec     = oth_cnt - CW'(1);
    assign own_rd_data = side ? r_rd_data : f_rd_data;
    assign oth_rd_data = side ? f_rd_data : r_rd_data;

    assign f_wr_en   = own_wr & !side;
    assign r_wr_en   = own_wr & side;
    assign f_rd_en   = side ? oth_rd : own_rd;
    assign r_rd_en   = side ? own_rd : oth_rd;
    assign f_rd_addr = side ? oth_rd_addr : own_rd_addr;
    assign r_rd_addr = side ? own_rd_addr : oth_rd_addr;

    assign req_stall = (state_reg != IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        own_cnt_n      = own_cnt;
        oth_cnt_n      = oth_cnt;
        own_rd         = 1'b0;
        own_wr         = 1'b0;
        oth_rd         = 1'b0;
        own_rd_addr    = own_dec[AW-1:0];
        own_wr_addr    = own_cnt[AW-1:0];
        oth_rd_addr    = oth_dec[AW-1:0];
        own_wr_data    = val_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.opcode;
                    val_next   = req.value;
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                unique case (op_reg) inside
                    tsd_pkg::OP_INS_FRONT, tsd_pkg::OP_INS_REAR:
                    begin
                        if (out_free)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next.data  = '0;
                            if (own_cnt == FULL_CNT)
                            begin
                                rsp_next.status = tsd_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                rsp_next.status = tsd_pkg::ST_OK;
                                own_wr          = 1'b1;
                                own_cnt_n       = own_cnt + CW'(1);
                            end
                            state_next = IDLE;
                        end
                    end
                    tsd_pkg::OP_DEL_FRONT, tsd_pkg::OP_DEL_REAR,
                    tsd_pkg::OP_PEEK_FRONT, tsd_pkg::OP_PEEK_REAR:
                    begin
                        if (own_cnt != '0)
                        begin
                            own_rd     = 1'b1;
                            state_next = READ;
                        end
                        else if (oth_cnt != '0)
                        begin
                            pend_next  = 1'b0;
                            state_next = XFER;
                        end
                        else if (out_free)
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_next.status = tsd_pkg::ST_EMPTY;
                            rsp_next.data   = '1;
                            state_next      = IDLE;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_next.status = tsd_pkg::ST_OK;
                            rsp_next.data   = '0;
                            state_next      = IDLE;
                        end
                    end
                endcase
            end
            READ:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = tsd_pkg::ST_OK;
                    rsp_next.data   = own_rd_data;
                    if (remove)
                    begin
                        own_cnt_n = own_dec;
                    end
                    state_next = IDLE;
                end
            end
            XFER:
            begin
                // pop other stack and push its previous top in the same cycle
                own_wr_data = oth_rd_data;
                pend_next   = 1'b0;
                if (oth_cnt != '0)
                begin
                    oth_rd    = 1'b1;
                    oth_cnt_n = oth_dec;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    own_wr    = 1'b1;
                    own_cnt_n = own_cnt + CW'(1);
                end
                if ((oth_cnt == '0) && !pend_reg)
                begin
                    state_next = EXEC;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase

        fcnt_next = side ? oth_cnt_n : own_cnt_n;
        rcnt_next = side ? own_cnt_n : oth_cnt_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            op_reg        <= '0;
            val_reg       <= '0;
            fcnt_reg      <= '0;
            rcnt_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            val_reg       <= val_next;
            fcnt_reg      <= fcnt_next;
            rcnt_reg      <= rcnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule
